### sv/assert_macros.svh
// Assertion macros used by the back end RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition in one cycle leads to another in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### sv/smconv_pkg.sv
// Types and constants of the same mode convolution unit.
`timescale 1ns / 1ps
package smconv_pkg;
  localparam int MAX_TAPS    = 64;
  localparam int TAP_AW      = $clog2(MAX_TAPS);
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int IDX_W       = 16;
  localparam int ACC_W       = 40;
  localparam int KLEN_W      = 7;
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;

  localparam logic FUNC_TAP    = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          is_sample;
    logic [TAP_AW-1:0]             tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last;
  } cmd_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    last;
  } res_t;
endpackage

### sv/smconv_front.sv
// Input side: accept requests, classify them and queue them for the back end.
`timescale 1ns / 1ps
module smconv_front import smconv_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_func,
  input  logic [TAP_AW-1:0]             in_tap_index,
  input  logic signed [COEF_BITS-1:0]   in_tap_value,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          cmd_empty,
  output cmd_t                          cmd_head,
  input  logic                          cmd_pop
);
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  always_comb begin
    cmd_in.is_sample = (in_func == FUNC_SAMPLE);
    cmd_in.tap_index = in_tap_index;
    cmd_in.value     = cmd_in.is_sample ? in_sample : in_tap_value;
    cmd_in.last      = cmd_in.is_sample & in_last_sample;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_empty = (cnt_r == 2'd0);
  assign cmd_head  = q_r[rp_r];
  assign do_push   = in_push & ~in_full;
  assign do_pop    = cmd_pop & ~cmd_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

### sv/smconv_back.sv
// Back end: tap and history memories, output sequencer and shared multiply-accumulate.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smconv_back import smconv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [KLEN_W-1:0] taps_len,
  input  logic              cmd_empty,
  input  cmd_t              cmd_head,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output res_t              res_data
);
  typedef enum logic [1:0] {S_IDLE, S_CALC, S_DRAIN, S_EMIT} state_t;

  state_t                        state_r;
  logic [KLEN_W-1:0]             held_r, d_r, a_r;
  logic [TAP_AW-1:0]             wr_ptr_r, newest_r;
  logic [IDX_W-1:0]              count_r, newest_idx_r;
  logic                          last_r, first_r;
  logic                          v1_r, v2_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;

  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   tap_mem  [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_rd_r;
  logic signed [COEF_BITS-1:0]   tap_rd_r;

  logic [KLEN_W-1:0] h, held_inc, a_hi, tail_hi, loop_d, t_idx;
  logic [TAP_AW-1:0] h_addr;
  logic              take, tap_wr, hist_wr, issue, fin;

  assign h        = taps_len >> 1;
  assign held_inc = (held_r == KLEN_W'(MAX_TAPS)) ? held_r : held_r + 1'b1;
  assign take     = (state_r == S_IDLE) & ~cmd_empty;
  assign cmd_pop  = take;
  assign tap_wr   = take & ~cmd_head.is_sample;
  assign hist_wr  = take & cmd_head.is_sample;
  assign issue    = (state_r == S_CALC);
  assign tail_hi  = taps_len - 1'b1 - h + d_r;
  assign a_hi     = ((held_r - 1'b1) < tail_hi) ? held_r - 1'b1 : tail_hi;
  assign t_idx    = h - d_r + a_r;
  assign h_addr   = newest_r - a_r[TAP_AW-1:0];
  // First tail output after the regular one: clip to the samples on hand.
  assign loop_d   = ((h - 1'b1) < (held_r - 1'b1)) ? h - 1'b1 : held_r - 1'b1;
  assign fin      = last_r & (d_r == '0);

  assign res_push       = (state_r == S_EMIT) & ~res_full;
  assign res_data.value = acc_r;
  assign res_data.index = newest_idx_r - IDX_W'(d_r);
  assign res_data.last  = fin;

  always_ff @(posedge clk) begin
    if (tap_wr) tap_mem[cmd_head.tap_index] <= cmd_head.value;
    if (hist_wr) hist_mem[wr_ptr_r] <= cmd_head.value;
    if (issue) begin
      hist_rd_r <= hist_mem[h_addr];
      tap_rd_r  <= tap_mem[t_idx[TAP_AW-1:0]];
    end
    prod_r <= hist_rd_r * tap_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_r       <= '0;
      wr_ptr_r     <= '0;
      newest_r     <= '0;
      count_r      <= '0;
      newest_idx_r <= '0;
      last_r       <= 1'b0;
      first_r      <= 1'b0;
      d_r          <= '0;
      a_r          <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      acc_r        <= '0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      if (v2_r) acc_r <= acc_r + ACC_W'(prod_r);
      unique case (state_r)
        S_IDLE: begin
          acc_r <= '0;
          a_r   <= '0;
          if (hist_wr) begin
            newest_r     <= wr_ptr_r;
            wr_ptr_r     <= wr_ptr_r + 1'b1;
            held_r       <= held_inc;
            newest_idx_r <= count_r;
            count_r      <= count_r + 1'b1;
            last_r       <= cmd_head.last;
            if (held_inc >= h + 1'b1) begin
              d_r     <= h;
              first_r <= 1'b1;
              state_r <= S_CALC;
            end else if (cmd_head.last) begin
              d_r     <= ((h - 1'b1) < (held_inc - 1'b1)) ? h - 1'b1 : held_inc - 1'b1;
              first_r <= 1'b0;
              state_r <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (a_r == a_hi) state_r <= S_DRAIN;
          else a_r <= a_r + 1'b1;
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (res_push) begin
            acc_r <= '0;
            a_r   <= '0;
            if (fin) begin
              held_r   <= '0;
              wr_ptr_r <= '0;
              count_r  <= '0;
              state_r  <= S_IDLE;
            end else if (last_r) begin
              d_r     <= first_r ? loop_d : d_r - 1'b1;
              first_r <= 1'b0;
              state_r <= S_CALC;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_held_range, held_r <= KLEN_W'(MAX_TAPS), "history count above depth")
  `ASSERT_NEXT(a_fin_clears, res_push && fin, held_r == '0 && count_r == '0, "final output left history")
  `ASSERT_ALWAYS(a_tap_in_len, !issue || t_idx < taps_len, "tap read beyond kernel length")
endmodule

### sv/smconv_resq.sv
// Two-entry result queue toward the receiver.
`timescale 1ns / 1ps
module smconv_resq import smconv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic res_push,
  input  res_t res_data,
  output logic res_full,
  output logic out_empty,
  input  logic out_pop,
  output res_t out_head
);
  res_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_head  = q_r[rp_r];
  assign do_push   = res_push & ~res_full;
  assign do_pop    = out_pop & ~out_empty;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= res_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

### sv/same_mode_convolution_unit.sv
// Top level of the streaming same mode convolution unit.
// Usage:
//   Input queue (in_push / in_full): a request with in_func low writes tap
//   in_tap_index; with in_func high it carries one sample, in_last_sample
//   marking the end of the signal. A request is taken when in_push is high
//   and in_full is low.
//   Result queue (out_empty / out_pop): out_value, out_index, out_last_out
//   hold the oldest result while out_empty is low; out_pop takes it.
//   APB port: register 0 at byte address 0 is kernel_length (reset 1).
// Back end: it handles one request at a time. An output sums N tap/sample
//   terms (N at most the kernel length), all through one shared 16x16
//   multiplier and the registered reads of the tap and history memories.
//   A sample other than the last gives at most one output; the last sample
//   flushes up to h + 1 outputs, h being half the kernel length.
// Reset clears the history count, sample index and queues; taps stay
//   undefined until written. When the receiver stops popping, the result
//   queue fills, the back end holds, and in_full rises once two requests wait.
`timescale 1ns / 1ps
module same_mode_convolution_unit import smconv_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_func,
  input  logic [TAP_AW-1:0]             in_tap_index,
  input  logic signed [COEF_BITS-1:0]   in_tap_value,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [ACC_W-1:0]       out_value,
  output logic [IDX_W-1:0]              out_index,
  output logic                          out_last_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  localparam logic [1:0] ADDR_KLEN = 2'd0;

  logic [KLEN_W-1:0] klen_r, taps_len;
  logic              cmd_empty, cmd_pop, res_full, res_push;
  cmd_t              cmd_head;
  res_t              res_data, out_head;

  // Register write on the access phase; reads at address 0 return the length register, others zero.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_KLEN) ? {{(32-KLEN_W){1'b0}}, klen_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_W'(1);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_KLEN) begin
      klen_r <= pwdata[KLEN_W-1:0];
    end
  end

  // Clamp: zero means one tap, anything above the store depth saturates.
  assign taps_len = (klen_r == '0) ? KLEN_W'(1) :
                    (klen_r > KLEN_W'(MAX_TAPS)) ? KLEN_W'(MAX_TAPS) : klen_r;

  smconv_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_func, .in_tap_index, .in_tap_value,
    .in_sample, .in_last_sample, .cmd_empty, .cmd_head, .cmd_pop
  );

  smconv_back u_back (
    .clk, .rst_n, .taps_len, .cmd_empty, .cmd_head, .cmd_pop,
    .res_full, .res_push, .res_data
  );

  smconv_resq u_resq (
    .clk, .rst_n, .res_push, .res_data, .res_full, .out_empty, .out_pop, .out_head
  );

  assign out_value    = out_head.value;
  assign out_index    = out_head.index;
  assign out_last_out = out_head.last;
endmodule
